>>> rtl/core/stpi_pkg.sv
// shared types and constants for the ramped stepper indexer
package stpi_pkg;

   localparam int TICKS_PER_MS = 1000;
   localparam int SUB_W        = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
   localparam int SHOT_BITS    = 16;

   // dividend holds (shot + 1) * steps_per_rev: 17 + 24 bits
   localparam int DIV_W  = SHOT_BITS + 1 + 24;
   localparam int DVS_W  = 16;
   localparam int DCNT_W = $clog2(DIV_W + 1);

   localparam logic [15:0] PULSE_TICKS  = 16'd3;
   localparam logic [15:0] SETTLE_TICKS = 16'd10;

   localparam logic [2:0] CSR_RAMP_LENGTH   = 3'd0;
   localparam logic [2:0] CSR_START_GAP     = 3'd1;
   localparam logic [2:0] CSR_MIN_GAP       = 3'd2;
   localparam logic [2:0] CSR_DIR_REVERSE   = 3'd3;
   localparam logic [2:0] CSR_SHOT_COUNT    = 3'd4;
   localparam logic [2:0] CSR_STEPS_PER_REV = 3'd5;
   localparam logic [2:0] CSR_INTERVAL_MS   = 3'd6;

   typedef enum logic [2:0] {
      CMD_TICK, CMD_JOG, CMD_INDEX, CMD_GOTO, CMD_ZERO, CMD_RUN, CMD_STOP, CMD_SYNC
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_SETTLE, PH_PULSE, PH_GAP, PH_RESTORE
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_MOD, SEQ_MUL, SEQ_TDIV, SEQ_GDIV, SEQ_FIN
   } seq_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

>>> rtl/core/stepper_indexer_ramped.sv
// ramped stepper indexer: one item is one microsecond tick, with an optional command
// most items need no division; a step gap or a shot target takes one pass through the divider,
// and a goto that needs its shot reduced first takes two; one item in work at a time.
// division runs in the 41-step divider; the result register lets the next item
// enter while a result waits. reset is synchronous and active high; it clears
// all motion state and loads the register defaults.
module stepper_indexer_ramped
   import stpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic signed [31:0] req_jog_steps,
   input  logic [15:0] req_shot_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_step_level,
   output logic        rsp_dir_level,
   output logic        rsp_driver_on,
   output logic        rsp_moving,
   output logic        rsp_running,
   output logic [15:0] rsp_shot_index,
   output logic signed [31:0] rsp_position,
   output logic        rsp_accepted,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration
   logic [15:0] ramp_len_ff, start_gap_ff, min_gap_ff, shot_count_ff;
   logic        dir_rev_ff;
   logic [23:0] spr_ff;
   logic [31:0] interval_ff;

   // sequencer and latched item
   seq_type     seq_ff, seq_in;
   cmd_type     cmd_ff, cmd_in;
   logic [31:0] jog_ff, jog_in;
   logic [SHOT_BITS:0] n_ff, n_in;

   // motion state
   phase_type   phase_ff, phase_in;
   logic [15:0] pc_ff, pc_in;
   logic [31:0] step_ff, step_in, total_ff, total_in;
   logic [15:0] ramp_ff, ramp_in;
   logic        rev_ff, rev_in, drv_ff, drv_in, run_ff, run_in, auto_ff, auto_in;
   logic [SHOT_BITS-1:0] shot_ff, shot_in, pshot_ff, pshot_in;
   logic [31:0] pos_ff, pos_in, pdelta_ff, pdelta_in;
   logic        pwrap_ff, pwrap_in;
   logic [31:0] dl_ff, dl_in, ms_ff, ms_in;
   logic [SUB_W-1:0] sub_ff, sub_in;

   // result register
   logic        rv_ff;
   logic        o_step_ff, o_dir_ff, o_drv_ff, o_mov_ff, o_run_ff, o_acc_ff;
   logic [15:0] o_shot_ff;
   logic [31:0] o_pos_ff;
   logic        o_step_in, o_dir_in, o_acc_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic        accept, fin_fire, tick_due, ramp_branch, gap_start;
   logic [15:0] pc_dec, d1, span, gap_x;
   logic [31:0] ramp32, xdiff, dl_diff;
   logic [15:0] shots_div;

   stpi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (seq_ff != SEQ_IDLE);
   assign fin_fire  = (seq_ff == SEQ_FIN) && (!rv_ff || !rsp_stall);

   assign pc_dec    = pc_ff - {15'd0, (pc_ff != 16'd0)};
   assign d1        = (min_gap_ff > start_gap_ff) ? start_gap_ff : min_gap_ff;
   assign span      = start_gap_ff - d1;
   assign ramp32    = {16'd0, ramp_ff};
   assign xdiff     = total_ff - 32'd1 - step_ff;
   assign ramp_branch = (ramp_ff != 16'd0) &&
                        ((step_ff < ramp32) || (step_ff >= total_ff - ramp32));
   assign gap_x     = (step_ff < ramp32) ? step_ff[15:0] : xdiff[15:0];
   assign gap_start = (phase_ff == PH_PULSE) && (pc_dec == 16'd0) && ramp_branch;
   assign dl_diff   = ms_ff - dl_ff;
   assign tick_due  = run_ff && !dl_diff[31];
   assign shots_div = (shot_count_ff == 16'd0) ? 16'd1 : shot_count_ff;

   // sequencer
   always_comb begin
      seq_in  = seq_ff;
      cmd_in  = cmd_ff;
      jog_in  = jog_ff;
      n_in    = n_ff;
      div_req = '0;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               cmd_in = cmd_type'(req_command);
               jog_in = req_jog_steps;
               n_in   = {1'b0, req_shot_number};
               if (phase_ff != PH_IDLE) begin
                  if (gap_start) begin
                     div_req.start    = 1'b1;
                     div_req.dividend = DIV_W'(span * gap_x);
                     div_req.divisor  = ramp_ff;
                     seq_in = SEQ_GDIV;
                  end else begin
                     seq_in = SEQ_FIN;
                  end
               end else if (cmd_type'(req_command) == CMD_INDEX ||
                            (cmd_type'(req_command) == CMD_TICK && tick_due)) begin
                  n_in   = {1'b0, shot_ff} + 1'b1;
                  seq_in = SEQ_MUL;
               end else if (cmd_type'(req_command) == CMD_GOTO) begin
                  if (shot_count_ff != 16'd0 && req_shot_number >= shot_count_ff) begin
                     div_req.start    = 1'b1;
                     div_req.dividend = DIV_W'(req_shot_number);
                     div_req.divisor  = shot_count_ff;
                     seq_in = SEQ_MOD;
                  end else begin
                     seq_in = SEQ_MUL;
                  end
               end else begin
                  seq_in = SEQ_FIN;
               end
            end
         end
         SEQ_MOD: begin
            if (div_rsp.done) begin
               n_in   = {1'b0, div_rsp.remainder};
               seq_in = SEQ_MUL;
            end
         end
         SEQ_MUL: begin
            div_req.start    = 1'b1;
            div_req.dividend = n_ff * spr_ff;
            div_req.divisor  = shots_div;
            seq_in = SEQ_TDIV;
         end
         SEQ_TDIV, SEQ_GDIV: begin
            if (div_rsp.done) seq_in = SEQ_FIN;
         end
         SEQ_FIN: begin
            if (fin_fire) seq_in = SEQ_IDLE;
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   // one tick of the indexer, applied when the item finishes
   always_comb begin : tick_logic
      logic        do_start, do_commit, do_resched, wrap, is_auto, dir;
      logic [31:0] delta, mag, dl_n, dd;
      logic [SHOT_BITS-1:0] sh_after;
      logic [15:0] g;
      logic [SUB_W:0] sub_p;

      phase_in  = phase_ff;  pc_in     = pc_ff;     step_in  = step_ff;
      total_in  = total_ff;  ramp_in   = ramp_ff;   rev_in   = rev_ff;
      drv_in    = drv_ff;    run_in    = run_ff;    auto_in  = auto_ff;
      shot_in   = shot_ff;   pshot_in  = pshot_ff;  pos_in   = pos_ff;
      pdelta_in = pdelta_ff; pwrap_in  = pwrap_ff;  dl_in    = dl_ff;
      ms_in     = ms_ff;

      do_start = 1'b0; do_commit = 1'b0; do_resched = 1'b0;
      wrap = 1'b0; is_auto = 1'b0; delta = '0; sh_after = shot_ff;
      o_acc_in = 1'b1;
      g = d1;

      if (phase_ff != PH_IDLE) begin
         pc_in = pc_dec;
         if (cmd_ff != CMD_TICK) o_acc_in = 1'b0;
         if (pc_dec == 16'd0) begin
            case (phase_ff)
               PH_SETTLE: begin
                  phase_in = PH_PULSE;
                  pc_in    = PULSE_TICKS;
               end
               PH_PULSE: begin
                  g = ramp_branch ? start_gap_ff - div_rsp.quotient[15:0] : d1;
                  phase_in = PH_GAP;
                  pc_in    = (g > PULSE_TICKS) ? g - PULSE_TICKS : 16'd1;
               end
               PH_GAP: begin
                  step_in = step_ff + 32'd1;
                  if (step_in < total_ff) begin
                     phase_in = PH_PULSE;
                     pc_in    = PULSE_TICKS;
                  end else begin
                     do_commit = 1'b1;
                     if (rev_ff) begin
                        phase_in = PH_RESTORE;
                        pc_in    = SETTLE_TICKS;
                     end else begin
                        phase_in   = PH_IDLE;
                        do_resched = 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in   = PH_IDLE;
                  rev_in     = 1'b0;
                  do_resched = 1'b1;
               end
            endcase
         end
      end else begin
         case (cmd_ff)
            CMD_TICK, CMD_INDEX: begin
               if (cmd_ff == CMD_INDEX || tick_due) begin
                  do_start = 1'b1;
                  delta    = div_rsp.quotient[31:0] - pos_ff;
                  sh_after = n_ff[SHOT_BITS-1:0];
                  wrap     = (n_ff >= {1'b0, shot_count_ff});
                  is_auto  = (cmd_ff == CMD_TICK);
               end
            end
            CMD_JOG: begin
               do_start = 1'b1;
               delta    = jog_ff;
            end
            CMD_GOTO: begin
               do_start = 1'b1;
               delta    = div_rsp.quotient[31:0] - pos_ff;
               sh_after = n_ff[SHOT_BITS-1:0];
            end
            CMD_ZERO: begin
               shot_in = '0;
               pos_in  = '0;
            end
            CMD_RUN: begin
               drv_in = 1'b1;
               run_in = 1'b1;
               dl_in  = ms_ff + interval_ff;
            end
            CMD_STOP: run_in = 1'b0;
            default:  dl_in  = ms_ff + interval_ff;
         endcase
      end

      mag = delta[31] ? 32'd0 - delta : delta;
      if (do_start) begin
         pdelta_in = delta;
         pshot_in  = sh_after;
         pwrap_in  = wrap;
         auto_in   = is_auto;
         if (delta == 32'd0) begin
            do_commit  = 1'b1;
            do_resched = 1'b1;
         end else begin
            rev_in   = delta[31];
            drv_in   = 1'b1;
            ramp_in  = ({15'd0, ramp_len_ff, 1'b0} > mag) ? mag[16:1] : ramp_len_ff;
            total_in = mag;
            step_in  = '0;
            phase_in = delta[31] ? PH_SETTLE : PH_PULSE;
            pc_in    = delta[31] ? SETTLE_TICKS : PULSE_TICKS;
         end
      end

      if (do_commit) begin
         if (pwrap_in) begin
            shot_in = '0;
            pos_in  = '0;
         end else begin
            shot_in = pshot_in;
            pos_in  = pos_ff + pdelta_in;
         end
      end

      // run-mode deadline moves on, with catch-up when already late
      dl_n = dl_ff + interval_ff;
      dd   = ms_ff - dl_n;
      if (do_resched && auto_in) begin
         auto_in = 1'b0;
         dl_in   = (dd != 32'd0 && !dd[31]) ? ms_ff + interval_ff : dl_n;
      end

      dir = !dir_rev_ff;
      if (rev_in && (phase_in == PH_SETTLE || phase_in == PH_PULSE || phase_in == PH_GAP))
         dir = !dir;
      o_dir_in  = dir;
      o_step_in = (phase_in == PH_PULSE);

      sub_p = {1'b0, sub_ff} + 1'b1;
      if (sub_p >= (SUB_W+1)'(TICKS_PER_MS)) begin
         sub_in = '0;
         ms_in  = ms_ff + 32'd1;
      end else begin
         sub_in = sub_p[SUB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      jog_ff <= jog_in;
      n_ff   <= n_in;
      if (fin_fire) begin
         o_step_ff <= o_step_in;
         o_dir_ff  <= o_dir_in;
         o_drv_ff  <= drv_in;
         o_mov_ff  <= (phase_in != PH_IDLE);
         o_run_ff  <= run_in;
         o_shot_ff <= shot_in;
         o_pos_ff  <= pos_in;
         o_acc_ff  <= o_acc_in;
      end
      if (reset) begin
         seq_ff <= SEQ_IDLE;
         rv_ff  <= 1'b0;
         ramp_len_ff <= 16'd16;  start_gap_ff <= 16'd2000; min_gap_ff <= 16'd500;
         dir_rev_ff  <= 1'b0;    shot_count_ff <= 16'd36;  spr_ff <= 24'd3200;
         interval_ff <= 32'd2000;
         phase_ff <= PH_IDLE; pc_ff <= '0; step_ff <= '0; total_ff <= '0; ramp_ff <= '0;
         rev_ff <= 1'b0; drv_ff <= 1'b0; run_ff <= 1'b0; auto_ff <= 1'b0;
         shot_ff <= '0; pshot_ff <= '0; pos_ff <= '0; pdelta_ff <= '0; pwrap_ff <= 1'b0;
         dl_ff <= '0; ms_ff <= '0; sub_ff <= '0;
      end else begin
         seq_ff <= seq_in;
         if (fin_fire)                rv_ff <= 1'b1;
         else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_RAMP_LENGTH:   ramp_len_ff   <= csr_wdata[15:0];
               CSR_START_GAP:     start_gap_ff  <= csr_wdata[15:0];
               CSR_MIN_GAP:       min_gap_ff    <= csr_wdata[15:0];
               CSR_DIR_REVERSE:   dir_rev_ff    <= csr_wdata[0];
               CSR_SHOT_COUNT:    shot_count_ff <= csr_wdata[15:0];
               CSR_STEPS_PER_REV: spr_ff        <= csr_wdata[23:0];
               CSR_INTERVAL_MS:   interval_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (fin_fire) begin
            phase_ff <= phase_in; pc_ff <= pc_in; step_ff <= step_in;
            total_ff <= total_in; ramp_ff <= ramp_in; rev_ff <= rev_in;
            drv_ff <= drv_in; run_ff <= run_in; auto_ff <= auto_in;
            shot_ff <= shot_in; pshot_ff <= pshot_in; pos_ff <= pos_in;
            pdelta_ff <= pdelta_in; pwrap_ff <= pwrap_in; dl_ff <= dl_in;
            ms_ff <= ms_in; sub_ff <= sub_in;
         end
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_step_level = o_step_ff;
   assign rsp_dir_level  = o_dir_ff;
   assign rsp_driver_on  = o_drv_ff;
   assign rsp_moving     = o_mov_ff;
   assign rsp_running    = o_run_ff;
   assign rsp_shot_index = o_shot_ff;
   assign rsp_position   = o_pos_ff;
   assign rsp_accepted   = o_acc_ff;

`ifndef SYNTHESIS
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (seq_ff == SEQ_MOD || seq_ff == SEQ_TDIV || seq_ff == SEQ_GDIV))
      else $error("divider result arrived while no division was pending");
   a_pulse_means_moving: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && o_step_ff) |-> o_mov_ff)
      else $error("step pulse shown outside a move");
`endif

endmodule

>>> rtl/core/stpi_div.sv
// shared restoring divider, one quotient bit per cycle
module stpi_div
   import stpi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = DCNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
`endif

endmodule
